### src/tkd_pkg.sv
// Shared types, constants and helpers for the terminal key decoder.
package tkd_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int DIM_LIM   = (MAX_DIM < 1024) ? MAX_DIM : 1024;
    localparam int DIM_W     = 11;
    localparam int POS_W     = 10;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIM_LIM - 1);

    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(80);
    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(24);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LBRK  = 8'h5b;  // '['
    localparam logic [7:0] CH_SS3   = 8'h4f;  // 'O'
    localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_QUIT  = 8'h71 & 8'h1f;  // ctrl-q

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ESC       = 3'd1,
        PH_CSI       = 3'd2,
        PH_SS3       = 3'd3,
        PH_OTHER     = 3'd4,
        PH_CSI_DIGIT = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        K_PLAIN = 4'd0,
        K_ESC   = 4'd1,
        K_LEFT  = 4'd2,
        K_RIGHT = 4'd3,
        K_UP    = 4'd4,
        K_DOWN  = 4'd5,
        K_PGUP  = 4'd6,
        K_PGDN  = 4'd7,
        K_HOME  = 4'd8,
        K_END   = 4'd9,
        K_DEL   = 4'd10
    } t_key;

    typedef struct packed {
        logic valid;   // item produces a result
        t_key key;
    } t_key_evt;

    // Last usable position for a screen size register.
    function automatic logic [POS_W-1:0] eff_last(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] dm1;
        dm1 = dim - DIM_W'(1);
        if (dim == '0) begin
            eff_last = '0;
        end else if (dim >= DIM_W'(DIM_LIM)) begin
            eff_last = LAST_POS;
        end else begin
            eff_last = dm1[POS_W-1:0];
        end
    endfunction

endpackage

### src/terminal_key_decoder_cursor_unit.sv
// Terminal key decoder top level: input register, decode, cursor, result register.
// The input register and then the result register lie between input transfer and result valid.
// Throughput: one item per cycle unless a result is held and the output is not ready.
// Timeout ticks in idle and bytes inside a sequence give no result.
// Reset (synchronous, active low) clears the parser to idle, the cursor to 0,0,
// the screen size to 80 columns by 24 rows and drops any held items.
module terminal_key_decoder_cursor_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // [7:0] in_byte
    input  logic                           i_s_tuser,  // [0] kind
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,  // [7:0] plain_byte, [17:8] cursor_col,
                                                       // [27:18] cursor_row, [31:28] zero
    output logic [4:0]                     o_m_tuser,  // [3:0] key_class, [4] quit_request
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tkd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tkd_pkg::DIM_W-1:0]      i_cfg_data
);
    import tkd_pkg::*;

    logic [DIM_W-1:0] r_cols, r_rows;
    logic             r_in_valid;
    logic             r_in_tick;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_key             r_out_key;
    logic [7:0]       r_out_plain;
    logic [POS_W-1:0] r_out_col, r_out_row;
    logic             r_out_quit;

    t_key_evt         evt;
    logic             fire;
    logic             emit;
    logic [POS_W-1:0] n_col, n_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end else if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    assign fire       = r_in_valid && (!evt.valid || !r_out_valid || i_m_tready);
    assign emit       = fire && evt.valid;
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_tick <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
    end

    tkd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (fire),
        .i_tick  (r_in_tick),
        .i_byte  (r_in_byte),
        .o_evt   (evt)
    );

    tkd_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (emit),
        .i_key   (evt.key),
        .i_cols  (r_cols),
        .i_rows  (r_rows),
        .o_col   (n_col),
        .o_row   (n_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_key   <= evt.key;
            r_out_plain <= (evt.key == K_PLAIN) ? r_in_byte : 8'h00;
            r_out_col   <= n_col;
            r_out_row   <= n_row;
            r_out_quit  <= (evt.key == K_PLAIN) && (r_in_byte == CH_QUIT);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_row, r_out_col, r_out_plain};
    assign o_m_tuser  = {r_out_quit, r_out_key};

endmodule

### src/tkd_parser.sv
// Escape sequence state machine: byte/timeout items to key events.
module tkd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_tick,
    input  logic [7:0]       i_byte,
    output tkd_pkg::t_key_evt o_evt
);
    import tkd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_digit;
    logic       is_digit;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_digit <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            if (r_phase == PH_CSI && !i_tick && is_digit) begin
                r_digit <= i_byte[3:0];
            end
        end
    end

    always_comb begin
        n_phase = PH_IDLE;
        if (!i_tick) begin
            case (r_phase)
                PH_IDLE: n_phase = (i_byte == CH_ESC) ? PH_ESC : PH_IDLE;
                PH_ESC: begin
                    if (i_byte == CH_LBRK) begin
                        n_phase = PH_CSI;
                    end else if (i_byte == CH_SS3) begin
                        n_phase = PH_SS3;
                    end else begin
                        n_phase = PH_OTHER;
                    end
                end
                PH_CSI:  n_phase = is_digit ? PH_CSI_DIGIT : PH_IDLE;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        o_evt.valid = 1'b1;
        o_evt.key   = K_ESC;
        if (i_tick) begin
            o_evt.valid = (r_phase != PH_IDLE);
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    o_evt.valid = (i_byte != CH_ESC);
                    o_evt.key   = K_PLAIN;
                end
                PH_ESC: o_evt.valid = 1'b0;
                PH_CSI: begin
                    o_evt.valid = !is_digit;
                    case (i_byte)
                        CH_A:    o_evt.key = K_UP;
                        CH_B:    o_evt.key = K_DOWN;
                        CH_C:    o_evt.key = K_RIGHT;
                        CH_D:    o_evt.key = K_LEFT;
                        CH_H:    o_evt.key = K_HOME;
                        CH_F:    o_evt.key = K_END;
                        default: o_evt.key = K_ESC;
                    endcase
                end
                PH_SS3: begin
                    if (i_byte == CH_H) begin
                        o_evt.key = K_HOME;
                    end else if (i_byte == CH_F) begin
                        o_evt.key = K_END;
                    end
                end
                PH_CSI_DIGIT: begin
                    if (i_byte == CH_TILDE) begin
                        case (r_digit)
                            4'd1, 4'd7: o_evt.key = K_HOME;
                            4'd3:       o_evt.key = K_DEL;
                            4'd4, 4'd8: o_evt.key = K_END;
                            4'd5:       o_evt.key = K_PGUP;
                            4'd6:       o_evt.key = K_PGDN;
                            default:    o_evt.key = K_ESC;
                        endcase
                    end
                end
                default: o_evt.key = K_ESC;
            endcase
        end
    end

endmodule

### src/tkd_cursor.sv
// Cursor position registers, moved by decoded keys and clamped to the screen.
module tkd_cursor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  tkd_pkg::t_key              i_key,
    input  logic [tkd_pkg::DIM_W-1:0]  i_cols,
    input  logic [tkd_pkg::DIM_W-1:0]  i_rows,
    output logic [tkd_pkg::POS_W-1:0]  o_col,
    output logic [tkd_pkg::POS_W-1:0]  o_row
);
    import tkd_pkg::*;

    logic [POS_W-1:0] r_col, r_row;
    logic [POS_W-1:0] last_col, last_row;

    assign last_col = eff_last(i_cols);
    assign last_row = eff_last(i_rows);

    always_comb begin
        o_col = r_col;
        o_row = r_row;
        case (i_key)
            K_LEFT:  o_col = (r_col != '0) ? r_col - POS_W'(1) : r_col;
            K_RIGHT: o_col = (r_col < last_col) ? r_col + POS_W'(1) : last_col;
            K_UP:    o_row = (r_row != '0) ? r_row - POS_W'(1) : r_row;
            K_DOWN:  o_row = (r_row < last_row) ? r_row + POS_W'(1) : last_row;
            K_PGUP:  o_row = '0;
            K_PGDN:  o_row = last_row;
            K_HOME:  o_col = '0;
            K_END:   o_col = last_col;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_en) begin
            r_col <= o_col;
            r_row <= o_row;
        end
    end

endmodule
